@@ sv/tsh_pkg.sv @@
// ----------------------------------------------------------------------------
// tsh_pkg - shared types and constants for the turn signal sequencer
// Mode codes, button masks and the architectural state record.
// ----------------------------------------------------------------------------
package tsh_pkg;

  localparam int unsigned BTN_W  = 5;
  localparam int unsigned LED_W  = 16;
  localparam int unsigned STEP_W = 3;
  localparam int unsigned MODE_W = 3;

  // blink mode codes
  localparam logic [MODE_W-1:0] MODE_IDLE  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_L_ON  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_L_OFF = 3'd2;
  localparam logic [MODE_W-1:0] MODE_R_ON  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_R_OFF = 3'd4;
  localparam logic [MODE_W-1:0] MODE_H_ON  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_H_OFF = 3'd6;

  localparam logic [BTN_W-1:0] LEFT_BIT   = 5'b00010;
  localparam logic [BTN_W-1:0] RIGHT_BIT  = 5'b01000;
  localparam logic [BTN_W-1:0] HAZARD_BIT = 5'b10000;

  localparam logic [STEP_W-1:0] STEP_MAX     = 3'd7;
  localparam logic [STEP_W-1:0] ON_LAST_STEP  = 3'd5;
  localparam logic [STEP_W-1:0] OFF_LAST_STEP = 3'd2;
  localparam int unsigned       LEFT_BASE    = 10;

  typedef struct packed {
    logic              press_latched;
    logic [MODE_W-1:0] mode;
    logic [LED_W-1:0]  leds;
    logic [STEP_W-1:0] step;
    logic              hold_clear;
    logic              count_en;
    logic              stop_req;
  } tsh_state_t;

  localparam tsh_state_t STATE_RESET = '{
    press_latched: 1'b0,
    mode:          MODE_IDLE,
    leds:          '0,
    step:          '0,
    hold_clear:    1'b1,
    count_en:      1'b0,
    stop_req:      1'b0
  };

endpackage

@@ sv/tsh_step.sv @@
// ----------------------------------------------------------------------------
// tsh_step - next-state logic for one button poll
// Step counter update, press filter and the blink mode machine.
// ----------------------------------------------------------------------------
module tsh_step import tsh_pkg::*; (
  input  tsh_state_t       state_i,
  input  logic [BTN_W-1:0] buttons_i,
  input  logic             tick_i,
  output tsh_state_t       state_o
);

  logic [STEP_W-1:0] step_t;
  logic [BTN_W-1:0]  pressed;
  logic [BTN_W-1:0]  mask;
  logic              is_on;
  logic              is_off;
  logic              use_left;
  logic              use_right;
  logic              hit;
  logic [MODE_W-1:0] next_mode;
  logic [LED_W-1:0]  side;
  tsh_state_t        nxt;

  always_comb begin
    step_t = state_i.step;
    if (tick_i) begin
      if (state_i.hold_clear) begin
        step_t = '0;
      end else if (state_i.count_en && (state_i.step != STEP_MAX)) begin
        step_t = state_i.step + 3'd1;
      end
    end
  end

  // only the first nonzero poll of a press gets through
  assign pressed = state_i.press_latched ? '0 : buttons_i;

  always_comb begin
    mask      = '0;
    is_on     = 1'b0;
    is_off    = 1'b0;
    use_left  = 1'b0;
    use_right = 1'b0;
    next_mode = MODE_IDLE;
    case (state_i.mode)
      MODE_L_ON: begin
        mask = LEFT_BIT; is_on = 1'b1; use_left = 1'b1; next_mode = MODE_L_OFF;
      end
      MODE_L_OFF: begin
        mask = LEFT_BIT; is_off = 1'b1; next_mode = MODE_L_ON;
      end
      MODE_R_ON: begin
        mask = RIGHT_BIT; is_on = 1'b1; use_right = 1'b1; next_mode = MODE_R_OFF;
      end
      MODE_R_OFF: begin
        mask = RIGHT_BIT; is_off = 1'b1; next_mode = MODE_R_ON;
      end
      MODE_H_ON: begin
        mask = HAZARD_BIT; is_on = 1'b1; use_left = 1'b1; use_right = 1'b1;
        next_mode = MODE_H_OFF;
      end
      MODE_H_OFF: begin
        mask = HAZARD_BIT; is_off = 1'b1; next_mode = MODE_H_ON;
      end
      default: begin
        next_mode = MODE_IDLE;
      end
    endcase
  end

  assign hit = |(pressed & mask);

  always_comb begin
    nxt               = state_i;
    nxt.press_latched = |buttons_i;
    nxt.step          = step_t;
    side              = '0;
    if (is_on) begin
      nxt.count_en = 1'b1;
      if (hit) begin
        nxt.stop_req = 1'b1;
      end else if (step_t > ON_LAST_STEP) begin
        nxt.mode       = next_mode;
        nxt.step       = '0;
        nxt.count_en   = 1'b0;
        nxt.hold_clear = 1'b0;
      end
      // steps six and seven light nothing on either side
      if (nxt.step <= ON_LAST_STEP) begin
        if (use_left) begin
          side[4'(LEFT_BASE) + {1'b0, nxt.step}] = 1'b1;
        end
        if (use_right) begin
          side[{1'b0, ON_LAST_STEP - nxt.step}] = 1'b1;
        end
      end
      nxt.leds = state_i.leds | side;
    end else if (is_off) begin
      nxt.count_en = 1'b1;
      nxt.leds     = '0;
      if (hit || state_i.stop_req) begin
        nxt.mode = MODE_IDLE;
      end else if (step_t > OFF_LAST_STEP) begin
        nxt.mode       = next_mode;
        nxt.step       = '0;
        nxt.count_en   = 1'b0;
        nxt.hold_clear = 1'b0;
      end
    end else begin
      nxt.mode       = MODE_IDLE;
      nxt.count_en   = 1'b0;
      nxt.leds       = '0;
      nxt.hold_clear = 1'b1;
      nxt.stop_req   = 1'b0;
      if (|(pressed & (LEFT_BIT | RIGHT_BIT | HAZARD_BIT))) begin
        nxt.hold_clear = 1'b0;
        nxt.count_en   = 1'b1;
        if (|(pressed & LEFT_BIT)) begin
          nxt.mode = MODE_L_ON;
        end else if (|(pressed & RIGHT_BIT)) begin
          nxt.mode = MODE_R_ON;
        end else begin
          nxt.mode = MODE_H_ON;
        end
      end
    end
  end

  assign state_o = nxt;

endmodule

@@ sv/turn_signal_hazard_sequencer.sv @@
// ----------------------------------------------------------------------------
// turn_signal_hazard_sequencer - sequential turn signal and hazard controller
// Button polls in, LED drive patterns out, one pattern per poll.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one button poll per request: five raw button
//   bits and a tick flag saying a timer period elapsed before the poll.
//   The master stream returns the 16-bit LED pattern after that poll.
//   Each poll lands in an input register; the step logic then reads it
//   together with the sequencer state and writes the result register and
//   the new state in the same cycle.
//   Two register stages: the input register, then the result register that
//   drives the master side. Throughput is one poll per cycle while the
//   receiver does not stall, set by the state loop through the step logic.
//   While the receiver stalls, the result register holds its pattern, the
//   input register fills, and s_axis_tready drops until the result is taken.
//   Reset empties both registers and puts the sequencer in idle with all
//   LEDs dark, the step counter held at zero and no press latched.
// ----------------------------------------------------------------------------
module turn_signal_hazard_sequencer import tsh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [4:0] buttons, [5] tick, [7:6] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [15:0] leds
);

  logic             in_valid_q;
  logic [BTN_W-1:0] buttons_q;
  logic             tick_q;
  logic             out_valid_q;
  logic [LED_W-1:0] leds_q;
  logic             advance;
  tsh_state_t       state_q;
  tsh_state_t       state_d;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      buttons_q <= s_axis_tdata[BTN_W-1:0];
      tick_q    <= s_axis_tdata[BTN_W];
    end
  end

  tsh_step u_step (
    .state_i   (state_q),
    .buttons_i (buttons_q),
    .tick_i    (tick_q),
    .state_o   (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      leds_q <= state_d.leds;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = leds_q;

`ifndef SYNTH
  // idle always drives the LEDs dark
  a_idle_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.mode == MODE_IDLE) |-> (state_q.leds == '0))
    else $error("leds lit while idle");

  // the counter is only held clear from idle
  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.hold_clear |-> (state_q.mode == MODE_IDLE))
    else $error("hold_clear set outside idle");

  // a poll that moves on always leaves a result behind
  a_adv_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed poll produced no result");

  // a result the receiver did not take is not overwritten
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !advance)
    else $error("result register overrun");
`endif

endmodule

@@ tb/sv/tb_turn_signal_hazard_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_turn_signal_hazard_sequencer - stream level test of the blink sequencer
// Button polls go in through the slave stream and LED patterns come back on
// the master stream. A behavioral sequencer inside a scoreboard predicts each
// pattern. Directed polls come first, then random press and tick sequences
// under changing sender gaps, receiver stalls and two long receiver hold-offs.
// ----------------------------------------------------------------------------
module tb_turn_signal_hazard_sequencer import tsh_pkg::*;;

  localparam int unsigned RANDOM_POLLS = 1200;
  localparam int unsigned PHASE_LEN    = RANDOM_POLLS / 4;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_CYCLES  = 80;

  // predicts the pattern after every accepted poll and checks the returned ones
  class led_scoreboard;
    tsh_state_t       seq;
    logic [LED_W-1:0] pending_leds[$];
    int unsigned      errors;

    function new();
      seq    = STATE_RESET;
      errors = 0;
    endfunction

    function logic [LED_W-1:0] lamp_bits(bit left_on, bit right_on, logic [STEP_W-1:0] s);
      logic [LED_W-1:0] v;
      v = '0;
      // left steps 6 and 7 run past bit 15 and vanish
      if (left_on) v = v | LED_W'(32'd1 << (int'(s) + LEFT_BASE));
      if (right_on && s <= ON_LAST_STEP) v = v | LED_W'(32'd1 << (ON_LAST_STEP - s));
      return v;
    endfunction

    function void on_phase(logic [BTN_W-1:0] pressed, logic [BTN_W-1:0] mask,
                           logic [MODE_W-1:0] off_mode, bit left_on, bit right_on);
      bit hit;
      hit = |(pressed & mask);
      seq.count_en = 1'b1;
      if (hit) seq.stop_req = 1'b1;
      if (!hit && seq.step > ON_LAST_STEP) begin
        seq.mode       = off_mode;
        seq.step       = '0;
        seq.count_en   = 1'b0;
        seq.hold_clear = 1'b0;
      end
      seq.leds = seq.leds | lamp_bits(left_on, right_on, seq.step);
    endfunction

    function void off_phase(logic [BTN_W-1:0] pressed, logic [BTN_W-1:0] mask,
                            logic [MODE_W-1:0] on_mode);
      bit hit;
      hit = |(pressed & mask);
      seq.count_en = 1'b1;
      seq.leds     = '0;
      if (hit || seq.stop_req) begin
        seq.mode = MODE_IDLE;
      end else if (seq.step > OFF_LAST_STEP) begin
        seq.mode       = on_mode;
        seq.step       = '0;
        seq.count_en   = 1'b0;
        seq.hold_clear = 1'b0;
      end
    endfunction

    function void note_poll(logic [BTN_W-1:0] btn, logic tick);
      logic [BTN_W-1:0] pressed;
      if (tick) begin
        if (seq.hold_clear) seq.step = '0;
        else if (seq.count_en && seq.step < STEP_MAX) seq.step = seq.step + 1'b1;
      end
      // only the first nonzero poll of a press gets through
      if (!seq.press_latched) begin
        pressed = btn;
        if (btn != '0) seq.press_latched = 1'b1;
      end else begin
        pressed = '0;
        if (btn == '0) seq.press_latched = 1'b0;
      end
      case (seq.mode)
        MODE_L_ON:  on_phase(pressed, LEFT_BIT, MODE_L_OFF, 1'b1, 1'b0);
        MODE_L_OFF: off_phase(pressed, LEFT_BIT, MODE_L_ON);
        MODE_R_ON:  on_phase(pressed, RIGHT_BIT, MODE_R_OFF, 1'b0, 1'b1);
        MODE_R_OFF: off_phase(pressed, RIGHT_BIT, MODE_R_ON);
        MODE_H_ON:  on_phase(pressed, HAZARD_BIT, MODE_H_OFF, 1'b1, 1'b1);
        MODE_H_OFF: off_phase(pressed, HAZARD_BIT, MODE_H_ON);
        default: begin
          seq.mode       = MODE_IDLE;
          seq.count_en   = 1'b0;
          seq.leds       = '0;
          seq.hold_clear = 1'b1;
          seq.stop_req   = 1'b0;
          if (|(pressed & (LEFT_BIT | RIGHT_BIT | HAZARD_BIT))) begin
            seq.hold_clear = 1'b0;
            seq.count_en   = 1'b1;
            if (|(pressed & LEFT_BIT)) seq.mode = MODE_L_ON;
            else if (|(pressed & RIGHT_BIT)) seq.mode = MODE_R_ON;
            else seq.mode = MODE_H_ON;
          end
        end
      endcase
      pending_leds.push_back(seq.leds);
    endfunction

    function void check_leds(logic [LED_W-1:0] got);
      logic [LED_W-1:0] want;
      if (pending_leds.size() == 0) begin
        $error("leds: unexpected pattern, actual %h", got);
        errors++;
        return;
      end
      want = pending_leds.pop_front();
      if (got !== want) begin
        $error("leds mismatch: expected %h, actual %h", want, got);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_leds.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;

  led_scoreboard sb;
  int unsigned   idle_pct;
  int unsigned   stall_pct;
  bit            hold_req;
  bit            hold_ack;
  int unsigned   hold_left;
  int unsigned   cycle_cnt;
  logic [4:0]    prev_btn;

  turn_signal_hazard_sequencer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // requests and results are sampled with their pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_poll(s_axis_tdata[4:0], s_axis_tdata[5]);
      if (m_axis_tvalid && m_axis_tready) sb.check_leds(m_axis_tdata);
    end
  end

  // receiver: random stalls, plus a long hold-off whenever one is asked for
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_poll(input logic [4:0] btn, input logic tick);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, tick, btn};
    do @(posedge clk_i); while (!s_axis_tready);
    prev_btn = btn;
  endtask

  task automatic send_random_poll();
    int unsigned      pick;
    logic [BTN_W-1:0] btn;
    logic             tick;
    pick = $urandom_range(99);
    tick = ($urandom_range(99) < 65);
    if (pick < 55) begin
      btn = '0;
    end else if (pick < 70) begin
      case ($urandom_range(2))
        0:       btn = LEFT_BIT;
        1:       btn = RIGHT_BIT;
        default: btn = HAZARD_BIT;
      endcase
    end else if (pick < 80) begin
      // keep the button down so the press filter sees a held press
      btn = prev_btn;
    end else begin
      btn = BTN_W'($urandom_range(31));
    end
    send_poll(btn, tick);
  endtask

  initial begin
    logic [5:0] directed[$];
    sb            = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    idle_pct      = 0;
    stall_pct     = 0;
    hold_req      = 1'b0;
    hold_ack      = 1'b0;
    hold_left     = 0;
    cycle_cnt     = 0;
    prev_btn      = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // {tick, buttons}: all buttons at once, a held press, a full left cycle,
    // same button again, right and hazard starts, and the bits that only
    // count as nonzero
    directed = '{6'h00, 6'h3f, 6'h1f, 6'h20, 6'h20, 6'h20, 6'h20, 6'h20,
                 6'h20, 6'h20, 6'h20, 6'h20, 6'h02, 6'h20, 6'h20, 6'h28,
                 6'h20, 6'h08, 6'h20, 6'h20, 6'h30, 6'h25, 6'h20, 6'h10,
                 6'h20};
    foreach (directed[i]) send_poll(directed[i][4:0], directed[i][5]);

    for (int unsigned n = 0; n < RANDOM_POLLS; n++) begin
      case (n / PHASE_LEN)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 54; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 54; end
        default: begin idle_pct = 30; stall_pct = 30; end
      endcase
      // long receiver hold-off while polls keep coming
      if (n == 100 || n == 3 * PHASE_LEN + 50) hold_req = ~hold_req;
      send_random_poll();
    end
    s_axis_tvalid <= 1'b0;

    // let the monitor note the last request before draining
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
